/* hdl/mta_pkg.sv */
// Shared types and constants of the multilane traffic automaton.
`default_nettype none
package mta_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ROAD_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LANE_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_SPEED   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOWDOWN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LANE_CHANGE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_SEED = 3'd5;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_STEP   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] KIND_EMPTY   = 2'd0;
  localparam logic [1:0] KIND_CAR     = 2'd1;
  localparam logic [1:0] KIND_BARRIER = 2'd2;
  localparam logic [1:0] KIND_UNUSED  = 2'd3;

  localparam logic [1:0] MOVE_NONE  = 2'd0;
  localparam logic [1:0] MOVE_DOWN  = 2'd1;
  localparam logic [1:0] MOVE_UP    = 2'd2;

  localparam int          LFSR_W       = 16;
  localparam logic [15:0] SEED_RESET   = 16'd44257;
  localparam logic [12:0] RECIP_100    = 13'd5242;
  localparam int          RECIP_SHIFT  = 19;
  localparam logic [7:0]  PERCENT_BASE = 8'd100;

  typedef struct packed {
    logic [1:0] opcode;
    logic [9:0] cell_pos;
    logic [1:0] cell_lane;
    logic [1:0] cell_kind_in;
    logic [3:0] car_speed_in;
    logic       slow_zone_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  cell_kind_out;
    logic [3:0]  car_speed_out;
    logic        slow_zone_out;
    logic [12:0] car_total;
  } out_item_t;

  typedef enum logic [1:0] {
    DR_IDLE,
    DR_MUL,
    DR_SUB,
    DR_DONE
  } draw_st_e;

  typedef enum logic [1:0] {
    SC_OWN,
    SC_LEFT,
    SC_RIGHT
  } scan_e;

  typedef enum logic [5:0] {
    ST_INIT,
    ST_IDLE,
    ST_WR_RD,
    ST_WR_WR,
    ST_OUT_RD,
    ST_OUT_CAP,
    ST_OUT,
    ST_CLR,
    ST_P1_RD,
    ST_P1_CHK,
    ST_SA_RD,
    ST_SA_USE,
    ST_SS_RD,
    ST_SS_USE,
    ST_SB_RD,
    ST_SB_USE,
    ST_DEC,
    ST_RSV,
    ST_DRAW_GO,
    ST_DRAW,
    ST_SL_RD,
    ST_SL_USE,
    ST_P1_WR,
    ST_P2_RD,
    ST_P2_CHK,
    ST_P2_TRD,
    ST_P2_TWR,
    ST_P3_RD,
    ST_P3_CHK,
    ST_P3_MOD,
    ST_P3_JRD,
    ST_P3_JWR,
    ST_P3_CWR
  } state_e;

endpackage
`default_nettype wire

/* hdl/mta_in_if.sv */
// Valid/ready channel carrying one command item.
`default_nettype none
interface mta_in_if;
  import mta_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/mta_out_if.sv */
// Valid/ready channel carrying one result item.
`default_nettype none
interface mta_out_if;
  import mta_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/mta_draw.sv */
// Random draw unit: 16-bit LFSR step followed by a reduction modulo 100.
`default_nettype none
module mta_draw (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        seed_load_i,
  input  logic [15:0] seed_i,
  input  logic        start_i,
  output logic        done_o,
  output logic [6:0]  value_o
);
  import mta_pkg::*;

  draw_st_e           st_q, st_d;
  logic [LFSR_W-1:0]  lfsr_q;
  logic [28:0]        prod_q;
  logic [7:0]         rem_q;
  logic               fb;
  logic [9:0]         quot;

  assign fb   = lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5];
  assign quot = prod_q[28:RECIP_SHIFT];

  always_comb begin
    st_d = st_q;
    case (st_q)
      DR_IDLE: begin
        if (start_i) begin
          st_d = DR_MUL;
        end
      end
      DR_MUL:  st_d = DR_SUB;
      DR_SUB:  st_d = DR_DONE;
      DR_DONE: st_d = DR_IDLE;
      default: st_d = DR_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= DR_IDLE;
      lfsr_q <= SEED_RESET;
    end else begin
      st_q <= st_d;
      if (seed_load_i) begin
        lfsr_q <= seed_i;
      end else if (st_q == DR_IDLE && start_i) begin
        lfsr_q <= {fb, lfsr_q[LFSR_W-1:1]};
      end
    end
  end

  // The reciprocal underestimates the quotient by at most one, so the
  // remainder stays below twice the base and one correction suffices.
  always_ff @(posedge clk_i) begin
    prod_q <= 29'(lfsr_q) * 29'(RECIP_100);
    rem_q  <= 8'(17'(lfsr_q) - 17'(quot) * 17'(PERCENT_BASE));
  end

  assign done_o  = (st_q == DR_DONE);
  assign value_o = (rem_q >= PERCENT_BASE) ? 7'(rem_q - PERCENT_BASE) : 7'(rem_q);

endmodule
`default_nettype wire

/* hdl/multilane_traffic_automaton_step.sv */
// Cell reads give their result through the states ST_OUT_RD and ST_OUT_CAP; writes pass
// ST_WR_RD and ST_WR_WR first. The next command can be taken in the cycle after the result
// transfer. A step walks the grid through single-port memories sharing one address: a pass
// over the lanes*length cells to clear moves, per car a scan per direction, a walk over slow
// zones and a draw, then two more passes. After reset a clearing pass over all DEPTH cells
// empties the grid before the first item is taken; configuration writes are taken throughout.
`default_nettype none
module multilane_traffic_automaton_step #(
  parameter int MAX_ROAD_LENGTH = 1024,
  parameter int MAX_LANES       = 4,
  parameter int SPEED_BITS      = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mta_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mta_pkg::CFG_DATA_W-1:0] cfg_data_i,
  mta_in_if.sink                         in_if,
  mta_out_if.source                      out_if
);
  import mta_pkg::*;

  localparam int POSW      = (MAX_ROAD_LENGTH > 1) ? $clog2(MAX_ROAD_LENGTH) : 1;
  localparam int LW        = $clog2(MAX_ROAD_LENGTH + 1);
  localparam int LANEW     = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
  localparam int NW        = $clog2(MAX_LANES + 1);
  localparam int SB        = SPEED_BITS;
  localparam int AW        = LANEW + POSW;
  localparam int DEPTH     = 2 ** AW;
  localparam int CW        = $clog2(DEPTH + 1);
  localparam int CELLW     = SB + 3;
  localparam int TW        = ((POSW > SB) ? POSW : SB) + 1;
  localparam int SPEED_MAX = (1 << SB) - 1;
  localparam int LEN_RST   = (1024 > MAX_ROAD_LENGTH) ? MAX_ROAD_LENGTH : 1024;
  localparam int TOP_RST   = (5 > SPEED_MAX) ? SPEED_MAX : 5;

  // Configuration.
  logic [LW-1:0] len_q;
  logic [NW-1:0] lanes_q;
  logic [SB-1:0] top_q;
  logic [6:0]    sd_q;
  logic          lce_q;
  logic [LW-1:0] len_w;
  logic [NW-1:0] lanes_w;
  logic [SB-1:0] top_w;
  logic [10:0]   len_raw;
  logic [2:0]    lanes_raw;
  logic [3:0]    top_raw;
  logic          seed_load;
  logic [15:0]   seed_val;

  // Sequencer state.
  state_e          state_q, state_d;
  scan_e           scan_q, scan_d;
  logic [9:0]      ipos_q, ipos_d;
  logic [1:0]      ilane_q, ilane_d;
  logic [1:0]      ikind_q, ikind_d;
  logic [3:0]      ispd_q, ispd_d;
  logic            islow_q, islow_d;
  logic            iok_q, iok_d;
  logic [LANEW-1:0] lane_q, lane_d;
  logic [POSW-1:0] pos_q, pos_d;
  logic [LANEW-1:0] slane_q, slane_d;
  logic [POSW-1:0] ptr_q, ptr_d;
  logic [SB:0]     cnt_q, cnt_d;
  logic [SB-1:0]   sp_q, sp_d;
  logic [SB-1:0]   gap_q, gap_d;
  logic [SB-1:0]   gl_q, gl_d;
  logic [SB-1:0]   gr_q, gr_d;
  logic            cslow_q, cslow_d;
  logic [TW-1:0]   tmp_q, tmp_d;
  logic [CW-1:0]   cars_q, cars_d;
  logic [AW-1:0]   clr_q, clr_d;
  out_item_t       out_q, out_d;

  // Memory ports.
  logic [CELLW-1:0] grid_mem [DEPTH];
  logic [1:0]       pend_mem [DEPTH];
  logic             resv_mem [DEPTH];
  logic [CELLW-1:0] rd_g_q;
  logic [1:0]       rd_p_q;
  logic             rd_r_q;
  logic [LANEW-1:0] m_lane;
  logic [POSW-1:0]  m_pos;
  logic [AW-1:0]    maddr;
  logic             g_we, p_we, r_we;
  logic [CELLW-1:0] g_wd;
  logic [1:0]       p_wd;
  logic             r_wd;

  logic [1:0]    g_kind;
  logic [SB-1:0] g_spd;
  logic          g_slow;

  logic          in_ready;
  logic          draw_start, draw_done;
  logic [6:0]    draw_val;

  logic [POSW-1:0] nxt_ptr, prv_ptr;
  logic            last_lane, has_right;
  logic            adv, nl, sc_fin;
  state_e          adv_same, adv_done;
  logic [POSW-1:0] adv_base;
  logic [SB-1:0]   sc_val;
  logic            mv_left, mv_right;
  logic [SB-1:0]   nsp;
  logic [1:0]      wkind;
  logic            old_car;

  assign g_kind = rd_g_q[SB+1:SB];
  assign g_spd  = rd_g_q[SB-1:0];
  assign g_slow = rd_g_q[SB+2];
  assign maddr  = {m_lane, m_pos};

  assign nxt_ptr   = (LW'(ptr_q) + LW'(1) == len_q) ? '0 : ptr_q + POSW'(1);
  assign prv_ptr   = (ptr_q == '0) ? POSW'(len_q - LW'(1)) : ptr_q - POSW'(1);
  assign last_lane = (NW'(lane_q) + NW'(1) == lanes_q);
  assign has_right = (NW'(lane_q) + NW'(1) < lanes_q);

  // Saturation of written configuration values.
  always_comb begin
    len_raw   = cfg_data_i[10:0];
    lanes_raw = cfg_data_i[2:0];
    top_raw   = cfg_data_i[3:0];
    if (len_raw < 11'd2) begin
      len_w = LW'(2);
    end else if (int'(len_raw) > MAX_ROAD_LENGTH) begin
      len_w = LW'(MAX_ROAD_LENGTH);
    end else begin
      len_w = LW'(len_raw);
    end
    if (lanes_raw < 3'd1) begin
      lanes_w = NW'(1);
    end else if (int'(lanes_raw) > MAX_LANES) begin
      lanes_w = NW'(MAX_LANES);
    end else begin
      lanes_w = NW'(lanes_raw);
    end
    if (top_raw < 4'd1) begin
      top_w = SB'(1);
    end else if (int'(top_raw) > SPEED_MAX) begin
      top_w = SB'(SPEED_MAX);
    end else begin
      top_w = SB'(top_raw);
    end
  end

  assign seed_load = cfg_we_i && (cfg_idx_i == CFG_RANDOM_SEED);
  assign seed_val  = (cfg_data_i == '0) ? 16'd1 : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= LW'(LEN_RST);
      lanes_q <= NW'(1);
      top_q   <= SB'(TOP_RST);
      sd_q    <= 7'd20;
      lce_q   <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROAD_LENGTH: len_q   <= len_w;
        CFG_LANE_COUNT:  lanes_q <= lanes_w;
        CFG_TOP_SPEED:   top_q   <= top_w;
        CFG_SLOWDOWN:    sd_q    <= cfg_data_i[6:0];
        CFG_LANE_CHANGE: lce_q   <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  mta_draw u_draw (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seed_load_i (seed_load),
    .seed_i      (seed_val),
    .start_i     (draw_start),
    .done_o      (draw_done),
    .value_o     (draw_val)
  );

  // Cell memory, pending moves and reservations share one address.
  always_ff @(posedge clk_i) begin
    if (g_we) begin
      grid_mem[maddr] <= g_wd;
    end
    rd_g_q <= grid_mem[maddr];
  end

  always_ff @(posedge clk_i) begin
    if (p_we) begin
      pend_mem[maddr] <= p_wd;
    end
    rd_p_q <= pend_mem[maddr];
  end

  always_ff @(posedge clk_i) begin
    if (r_we) begin
      resv_mem[maddr] <= r_wd;
    end
    rd_r_q <= resv_mem[maddr];
  end

  always_comb begin
    state_d = state_q;
    scan_d  = scan_q;
    ipos_d  = ipos_q;
    ilane_d = ilane_q;
    ikind_d = ikind_q;
    ispd_d  = ispd_q;
    islow_d = islow_q;
    iok_d   = iok_q;
    lane_d  = lane_q;
    pos_d   = pos_q;
    slane_d = slane_q;
    ptr_d   = ptr_q;
    cnt_d   = cnt_q;
    sp_d    = sp_q;
    gap_d   = gap_q;
    gl_d    = gl_q;
    gr_d    = gr_q;
    cslow_d = cslow_q;
    tmp_d   = tmp_q;
    cars_d  = cars_q;
    clr_d   = clr_q;
    out_d   = out_q;
    m_lane  = lane_q;
    m_pos   = pos_q;
    g_we    = 1'b0;
    p_we    = 1'b0;
    r_we    = 1'b0;
    g_wd    = '0;
    p_wd    = MOVE_NONE;
    r_wd    = 1'b0;
    in_ready   = 1'b0;
    draw_start = 1'b0;
    adv      = 1'b0;
    nl       = 1'b0;
    adv_base = pos_q;
    adv_same = state_q;
    adv_done = state_q;
    sc_fin   = 1'b0;
    sc_val   = '0;
    mv_left  = 1'b0;
    mv_right = 1'b0;
    nsp      = sp_q;
    wkind    = ikind_q;
    old_car  = 1'b0;

    case (state_q)
      ST_INIT: begin
        m_lane = clr_q[AW-1:POSW];
        m_pos  = clr_q[POSW-1:0];
        g_we   = 1'b1;
        clr_d  = clr_q + AW'(1);
        if (&clr_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_if.valid) begin
          ipos_d  = in_if.data.cell_pos;
          ilane_d = in_if.data.cell_lane;
          ikind_d = in_if.data.cell_kind_in;
          ispd_d  = in_if.data.car_speed_in;
          islow_d = in_if.data.slow_zone_in;
          iok_d   = (int'(in_if.data.cell_pos) < MAX_ROAD_LENGTH) &&
                    (int'(in_if.data.cell_lane) < MAX_LANES);
          if (in_if.data.opcode == OP_WRITE && iok_d) begin
            state_d = ST_WR_RD;
          end else if (in_if.data.opcode == OP_STEP) begin
            lane_d  = '0;
            pos_d   = '0;
            state_d = ST_CLR;
          end else begin
            state_d = ST_OUT_RD;
          end
        end
      end
      ST_WR_RD: begin
        m_lane  = LANEW'(ilane_q);
        m_pos   = POSW'(ipos_q);
        state_d = ST_WR_WR;
      end
      ST_WR_WR: begin
        m_lane  = LANEW'(ilane_q);
        m_pos   = POSW'(ipos_q);
        wkind   = (ikind_q == KIND_UNUSED) ? KIND_EMPTY : ikind_q;
        old_car = (g_kind == KIND_CAR);
        g_we    = 1'b1;
        g_wd    = {islow_q, wkind, (wkind == KIND_CAR) ? SB'(ispd_q) : SB'(0)};
        cars_d  = cars_q - CW'(old_car) + CW'(wkind == KIND_CAR);
        state_d = ST_OUT_RD;
      end
      ST_OUT_RD: begin
        m_lane  = LANEW'(ilane_q);
        m_pos   = POSW'(ipos_q);
        state_d = ST_OUT_CAP;
      end
      ST_OUT_CAP: begin
        if (iok_q) begin
          out_d.cell_kind_out = g_kind;
          out_d.car_speed_out = (g_kind == KIND_CAR) ? 4'(g_spd) : 4'd0;
          out_d.slow_zone_out = g_slow;
        end else begin
          out_d.cell_kind_out = KIND_EMPTY;
          out_d.car_speed_out = 4'd0;
          out_d.slow_zone_out = 1'b0;
        end
        out_d.car_total = 13'(cars_q);
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_if.ready) begin
          state_d = ST_IDLE;
        end
      end
      ST_CLR: begin
        p_we     = 1'b1;
        r_we     = 1'b1;
        adv      = 1'b1;
        adv_same = ST_CLR;
        adv_done = ST_P1_RD;
      end
      ST_P1_RD: begin
        state_d = ST_P1_CHK;
      end
      ST_P1_CHK: begin
        if (g_kind != KIND_CAR) begin
          adv      = 1'b1;
          adv_same = ST_P1_RD;
          adv_done = ST_P2_RD;
        end else begin
          sp_d    = (g_spd < top_q) ? g_spd + SB'(1) : g_spd;
          cslow_d = g_slow;
          gl_d    = '0;
          gr_d    = '0;
          scan_d  = SC_OWN;
          slane_d = lane_q;
          ptr_d   = pos_q;
          cnt_d   = (SB+1)'(1);
          state_d = ST_SA_RD;
        end
      end
      ST_SA_RD: begin
        if (cnt_q > {1'b0, top_q}) begin
          sc_fin = 1'b1;
          sc_val = top_q;
        end else begin
          m_lane  = slane_q;
          m_pos   = nxt_ptr;
          ptr_d   = nxt_ptr;
          state_d = ST_SA_USE;
        end
      end
      ST_SA_USE: begin
        if (g_kind != KIND_EMPTY || (scan_q != SC_OWN && rd_r_q)) begin
          sc_fin = 1'b1;
          sc_val = SB'(cnt_q - (SB+1)'(1));
        end else begin
          cnt_d   = cnt_q + (SB+1)'(1);
          state_d = ST_SA_RD;
        end
      end
      ST_SS_RD: begin
        m_lane  = slane_q;
        state_d = ST_SS_USE;
      end
      ST_SS_USE: begin
        if (g_kind != KIND_EMPTY || rd_r_q) begin
          sc_fin = 1'b1;
        end else begin
          cnt_d   = (SB+1)'(1);
          ptr_d   = pos_q;
          state_d = ST_SB_RD;
        end
      end
      ST_SB_RD: begin
        if (cnt_q > {1'b0, top_q}) begin
          cnt_d   = (SB+1)'(1);
          ptr_d   = pos_q;
          state_d = ST_SA_RD;
        end else begin
          m_lane  = slane_q;
          m_pos   = prv_ptr;
          ptr_d   = prv_ptr;
          state_d = ST_SB_USE;
        end
      end
      ST_SB_USE: begin
        // A car behind before any barrier blocks the change.
        if (g_kind == KIND_CAR) begin
          sc_fin = 1'b1;
        end else if (g_kind == KIND_BARRIER) begin
          cnt_d   = (SB+1)'(1);
          ptr_d   = pos_q;
          state_d = ST_SA_RD;
        end else begin
          cnt_d   = cnt_q + (SB+1)'(1);
          state_d = ST_SB_RD;
        end
      end
      ST_DEC: begin
        mv_left  = (gap_q < sp_q) && (gl_q > gap_q);
        mv_right = !mv_left && (gap_q < sp_q) && (gr_q > gap_q);
        if (mv_left) begin
          nsp = (gl_q < sp_q) ? gl_q : sp_q;
        end else if (mv_right) begin
          nsp = (gr_q < sp_q) ? gr_q : sp_q;
        end else begin
          nsp = (gap_q < sp_q) ? gap_q : sp_q;
        end
        sp_d = nsp;
        p_we = 1'b1;
        p_wd = mv_left ? MOVE_DOWN : (mv_right ? MOVE_UP : MOVE_NONE);
        if (mv_left) begin
          slane_d = lane_q - LANEW'(1);
          state_d = ST_RSV;
        end else if (mv_right) begin
          slane_d = lane_q + LANEW'(1);
          state_d = ST_RSV;
        end else begin
          state_d = ST_DRAW_GO;
        end
      end
      ST_RSV: begin
        m_lane  = slane_q;
        r_we    = 1'b1;
        r_wd    = 1'b1;
        state_d = ST_DRAW_GO;
      end
      ST_DRAW_GO: begin
        draw_start = 1'b1;
        state_d    = ST_DRAW;
      end
      ST_DRAW: begin
        if (draw_done) begin
          if (draw_val < sd_q && sp_q != '0) begin
            sp_d = sp_q - SB'(1);
          end
          cnt_d   = '0;
          ptr_d   = pos_q;
          state_d = ST_SL_RD;
        end
      end
      ST_SL_RD: begin
        // The bound follows the speed as it is braked inside the walk.
        if (cnt_q > {1'b0, sp_q}) begin
          state_d = ST_P1_WR;
        end else begin
          m_pos   = ptr_q;
          state_d = ST_SL_USE;
        end
      end
      ST_SL_USE: begin
        if (g_slow && sp_q > SB'(1)) begin
          sp_d = sp_q - SB'(1);
        end
        cnt_d   = cnt_q + (SB+1)'(1);
        ptr_d   = nxt_ptr;
        state_d = ST_SL_RD;
      end
      ST_P1_WR: begin
        g_we     = 1'b1;
        g_wd     = {cslow_q, KIND_CAR, sp_q};
        adv      = 1'b1;
        adv_same = ST_P1_RD;
        adv_done = ST_P2_RD;
      end
      ST_P2_RD: begin
        state_d = ST_P2_CHK;
      end
      ST_P2_CHK: begin
        if (rd_p_q == MOVE_NONE) begin
          adv      = 1'b1;
          adv_same = ST_P2_RD;
          adv_done = ST_P3_RD;
        end else begin
          sp_d    = g_spd;
          g_we    = 1'b1;
          g_wd    = {g_slow, KIND_EMPTY, SB'(0)};
          slane_d = (rd_p_q == MOVE_DOWN) ? lane_q - LANEW'(1) : lane_q + LANEW'(1);
          state_d = ST_P2_TRD;
        end
      end
      ST_P2_TRD: begin
        m_lane  = slane_q;
        state_d = ST_P2_TWR;
      end
      ST_P2_TWR: begin
        m_lane   = slane_q;
        g_we     = 1'b1;
        g_wd     = {g_slow, KIND_CAR, sp_q};
        cars_d   = cars_q - CW'(g_kind == KIND_CAR);
        adv      = 1'b1;
        adv_same = ST_P2_RD;
        adv_done = ST_P3_RD;
      end
      ST_P3_RD: begin
        state_d = ST_P3_CHK;
      end
      ST_P3_CHK: begin
        if (g_kind != KIND_CAR) begin
          adv      = 1'b1;
          adv_same = ST_P3_RD;
          adv_done = ST_OUT_RD;
        end else begin
          sp_d    = g_spd;
          cslow_d = g_slow;
          tmp_d   = TW'(pos_q) + TW'(g_spd);
          state_d = ST_P3_MOD;
        end
      end
      ST_P3_MOD: begin
        if (tmp_q >= TW'(len_q)) begin
          tmp_d = tmp_q - TW'(len_q);
        end else begin
          state_d = ST_P3_JRD;
        end
      end
      ST_P3_JRD: begin
        m_pos   = POSW'(tmp_q);
        state_d = ST_P3_JWR;
      end
      ST_P3_JWR: begin
        m_pos  = POSW'(tmp_q);
        g_we   = 1'b1;
        g_wd   = {g_slow, KIND_CAR, sp_q};
        cars_d = cars_q - CW'(g_kind == KIND_CAR && POSW'(tmp_q) != pos_q);
        if (POSW'(tmp_q) != pos_q) begin
          state_d = ST_P3_CWR;
        end else begin
          adv      = 1'b1;
          adv_same = ST_P3_RD;
          adv_done = ST_OUT_RD;
        end
      end
      ST_P3_CWR: begin
        g_we     = 1'b1;
        g_wd     = {cslow_q, KIND_EMPTY, SB'(0)};
        adv_same = ST_P3_RD;
        adv_done = ST_OUT_RD;
        // A car that wrapped round ends the pass over its lane.
        if (POSW'(tmp_q) < pos_q) begin
          nl = 1'b1;
        end else begin
          adv      = 1'b1;
          adv_base = POSW'(tmp_q);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (nl || (adv && (LW'(adv_base) + LW'(1) == len_q))) begin
      pos_d = '0;
      if (last_lane) begin
        lane_d  = '0;
        state_d = adv_done;
      end else begin
        lane_d  = lane_q + LANEW'(1);
        state_d = adv_same;
      end
    end else if (adv) begin
      pos_d   = adv_base + POSW'(1);
      state_d = adv_same;
    end

    if (sc_fin) begin
      case (scan_q)
        SC_OWN:  gap_d = sc_val;
        SC_LEFT: gl_d  = sc_val;
        default: gr_d  = sc_val;
      endcase
      if (scan_q == SC_OWN && lce_q && lane_q != '0) begin
        scan_d  = SC_LEFT;
        slane_d = lane_q - LANEW'(1);
        state_d = ST_SS_RD;
      end else if (scan_q != SC_RIGHT && lce_q && has_right) begin
        scan_d  = SC_RIGHT;
        slane_d = lane_q + LANEW'(1);
        state_d = ST_SS_RD;
      end else begin
        state_d = ST_DEC;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      scan_q  <= SC_OWN;
      clr_q   <= '0;
      cars_q  <= '0;
      lane_q  <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
      clr_q   <= clr_d;
      cars_q  <= cars_d;
      lane_q  <= lane_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ipos_q  <= ipos_d;
    ilane_q <= ilane_d;
    ikind_q <= ikind_d;
    ispd_q  <= ispd_d;
    islow_q <= islow_d;
    iok_q   <= iok_d;
    slane_q <= slane_d;
    ptr_q   <= ptr_d;
    cnt_q   <= cnt_d;
    sp_q    <= sp_d;
    gap_q   <= gap_d;
    gl_q    <= gl_d;
    gr_q    <= gr_d;
    cslow_q <= cslow_d;
    tmp_q   <= tmp_d;
    out_q   <= out_d;
  end

  assign in_if.ready  = in_ready;
  assign out_if.valid = (state_q == ST_OUT);
  assign out_if.data  = out_q;

`ifndef SYNTHESIS
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_if.ready && out_if.valid))
    else $error("command taken while a result is pending");

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("ready held after a command transfer");

  a_car_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cars_q) <= DEPTH)
    else $error("car count beyond grid size");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SA_USE || state_q == ST_SB_USE) |-> (cnt_q <= {1'b0, top_q}))
    else $error("scan ran past top speed");
`endif

endmodule
`default_nettype wire
